@@ rtl/shlex_pkg.sv @@
package shlex_pkg;

    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int RES_IW  = $clog2(MAX_RES);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_PIPE  = 8'h7c;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_DQUOT = 8'h22;

    typedef enum logic [1:0] {
        M_IDLE  = 2'd0,
        M_WORD  = 2'd1,
        M_OP    = 2'd2,
        M_QUOTE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        K_WORD   = 3'd0,
        K_OP     = 3'd1,
        K_IN     = 3'd2,
        K_OUT    = 3'd3,
        K_APPEND = 3'd4,
        K_END    = 3'd5,
        K_ERROR  = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] tok_char;
        t_kind      kind;
        logic       tok_first;
        logic       tok_last;
        logic       empty_tok;
    } t_tok;

    typedef struct packed {
        logic [CNT_W-1:0]     count;
        t_tok [MAX_RES-1:0]   toks;
    } t_bundle;

endpackage

@@ rtl/shlex_front.sv @@
module shlex_front import shlex_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_has_char,
    input  logic       i_line_end,
    input  logic       i_q_full,
    output logic       o_push,
    output t_bundle    o_bundle
);

    t_mode       r_mode, n_mode;
    logic [7:0]  r_qb, n_qb;
    logic        r_hv, n_hv;
    logic [7:0]  r_hb, n_hb;
    t_kind       r_hk, n_hk;
    logic        r_hf, n_hf;
    logic        r_qhb, n_qhb;

    logic        c_blank, c_meta, c_quote, c_opstart, c_gt, c_lt, c_paren;
    logic        c_eq_q, c_eq_h, s_go;
    logic [CNT_W-1:0] cnt;
    t_tok [MAX_RES-1:0] toks;
    t_kind       pair_kind;
    logic        accept;

    function automatic t_tok mk_tok(logic [7:0] ch, t_kind k, logic f, logic l, logic e);
        t_tok t;
        t.tok_char  = ch;
        t.kind      = k;
        t.tok_first = f;
        t.tok_last  = l;
        t.empty_tok = e;
        return t;
    endfunction

    // byte classes
    assign c_blank   = (i_ch == CH_SPACE) || (i_ch == CH_TAB) || (i_ch == CH_NL);
    assign c_opstart = (i_ch == CH_PIPE) || (i_ch == CH_AMP) || (i_ch == CH_SEMI);
    assign c_gt      = (i_ch == CH_GT);
    assign c_lt      = (i_ch == CH_LT);
    assign c_paren   = (i_ch == CH_LPAR) || (i_ch == CH_RPAR);
    assign c_meta    = c_blank || c_opstart || c_gt || c_lt || c_paren;
    assign c_quote   = (i_ch == CH_SQUOT) || (i_ch == CH_DQUOT);
    assign c_eq_q    = (i_ch == r_qb);
    assign c_eq_h    = r_hv && (i_ch == r_hb);
    assign pair_kind = c_gt ? K_APPEND : K_OP;

    // byte is handled as the start of a new token
    always_comb begin
        s_go = 1'b0;
        if (i_has_char) begin
            unique case (r_mode)
                M_IDLE:  s_go = 1'b1;
                M_WORD:  s_go = c_meta;
                M_OP:    s_go = !c_eq_h;
                M_QUOTE: s_go = 1'b0;
                default: s_go = 1'b0;
            endcase
        end
    end

    // next state after the byte (line end handled at the register)
    always_comb begin
        n_mode = r_mode;
        n_qb   = r_qb;
        n_hv   = r_hv;
        n_hb   = r_hb;
        n_hk   = r_hk;
        n_hf   = r_hf;
        n_qhb  = r_qhb;
        if (i_has_char) begin
            unique case (r_mode)
                M_QUOTE: begin
                    if (c_eq_q) begin
                        n_hv   = 1'b0;
                        n_hb   = '0;
                        n_hk   = K_WORD;
                        n_hf   = 1'b0;
                        n_qhb  = 1'b0;
                        n_mode = M_IDLE;
                    end else begin
                        n_hv  = 1'b1;
                        n_hb  = i_ch;
                        n_hk  = K_WORD;
                        n_hf  = !r_qhb;
                        n_qhb = 1'b1;
                    end
                end
                M_WORD: begin
                    if (!c_meta) begin
                        n_hv = 1'b1;
                        n_hb = i_ch;
                        n_hk = K_WORD;
                        n_hf = !r_hv;
                    end
                end
                M_OP: begin
                    if (c_eq_h) begin
                        n_hv   = 1'b0;
                        n_hb   = '0;
                        n_hk   = K_WORD;
                        n_hf   = 1'b0;
                        n_mode = M_IDLE;
                    end
                end
                M_IDLE: begin
                end
                default: begin
                end
            endcase
            if (s_go) begin
                n_hv   = 1'b0;
                n_hb   = '0;
                n_hk   = K_WORD;
                n_hf   = 1'b0;
                n_mode = M_IDLE;
                if (c_quote) begin
                    n_mode = M_QUOTE;
                    n_qb   = i_ch;
                    n_qhb  = 1'b0;
                end else if (c_opstart || c_gt) begin
                    n_hv   = 1'b1;
                    n_hb   = i_ch;
                    n_hk   = c_gt ? K_OUT : K_OP;
                    n_hf   = 1'b1;
                    n_mode = M_OP;
                end else if (!(c_blank || c_lt || c_paren)) begin
                    n_hv   = 1'b1;
                    n_hb   = i_ch;
                    n_hk   = K_WORD;
                    n_hf   = 1'b1;
                    n_mode = M_WORD;
                end
            end
        end
    end

    // results of the item
    always_comb begin
        cnt  = '0;
        toks = '0;
        if (i_has_char) begin
            unique case (r_mode)
                M_QUOTE: begin
                    if (c_eq_q) begin
                        if (r_hv) begin
                            toks[cnt[RES_IW-1:0]] = mk_tok(r_hb, r_hk, r_hf, 1'b1, 1'b0);
                            cnt = cnt + 1'b1;
                        end else if (!r_qhb) begin
                            toks[cnt[RES_IW-1:0]] = mk_tok('0, K_WORD, 1'b1, 1'b1, 1'b1);
                            cnt = cnt + 1'b1;
                        end
                    end else if (r_hv) begin
                        toks[cnt[RES_IW-1:0]] = mk_tok(r_hb, r_hk, r_hf, 1'b0, 1'b0);
                        cnt = cnt + 1'b1;
                    end
                end
                M_WORD: begin
                    if (r_hv) begin
                        toks[cnt[RES_IW-1:0]] = mk_tok(r_hb, r_hk, r_hf, c_meta, 1'b0);
                        cnt = cnt + 1'b1;
                    end
                end
                M_OP: begin
                    if (c_eq_h) begin
                        toks[cnt[RES_IW-1:0]] = mk_tok(r_hb, pair_kind, 1'b1, 1'b0, 1'b0);
                        cnt = cnt + 1'b1;
                        toks[cnt[RES_IW-1:0]] = mk_tok(i_ch, pair_kind, 1'b0, 1'b1, 1'b0);
                        cnt = cnt + 1'b1;
                    end else if (r_hv) begin
                        toks[cnt[RES_IW-1:0]] = mk_tok(r_hb, r_hk, 1'b1, 1'b1, 1'b0);
                        cnt = cnt + 1'b1;
                    end
                end
                M_IDLE: begin
                end
                default: begin
                end
            endcase
            if (s_go) begin
                if (c_lt) begin
                    toks[cnt[RES_IW-1:0]] = mk_tok(i_ch, K_IN, 1'b1, 1'b1, 1'b0);
                    cnt = cnt + 1'b1;
                end else if (c_paren) begin
                    toks[cnt[RES_IW-1:0]] = mk_tok(i_ch, K_OP, 1'b1, 1'b1, 1'b0);
                    cnt = cnt + 1'b1;
                end
            end
        end
        if (i_line_end) begin
            // flush: error for an open quote, else the held byte; then end marker
            if (n_mode == M_QUOTE) begin
                toks[cnt[RES_IW-1:0]] = mk_tok('0, K_ERROR, 1'b1, 1'b1, 1'b0);
                cnt = cnt + 1'b1;
            end else if (n_hv) begin
                toks[cnt[RES_IW-1:0]] = mk_tok(n_hb, n_hk, n_hf, 1'b1, 1'b0);
                cnt = cnt + 1'b1;
            end
            toks[cnt[RES_IW-1:0]] = mk_tok('0, K_END, 1'b1, 1'b1, 1'b0);
            cnt = cnt + 1'b1;
        end
    end

    assign o_ready         = !i_q_full;
    assign accept          = i_valid && o_ready;
    assign o_push          = accept && (cnt != '0);
    assign o_bundle.count  = cnt;
    assign o_bundle.toks   = toks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_line_end)) begin
            r_mode <= M_IDLE;
            r_qb   <= '0;
            r_hv   <= 1'b0;
            r_hb   <= '0;
            r_hk   <= K_WORD;
            r_hf   <= 1'b0;
            r_qhb  <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_qb   <= n_qb;
            r_hv   <= n_hv;
            r_hb   <= n_hb;
            r_hk   <= n_hk;
            r_hf   <= n_hf;
            r_qhb  <= n_qhb;
        end
    end

endmodule

@@ rtl/shlex_queue.sv @@
module shlex_queue import shlex_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_bundle o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/shlex_back.sv @@
module shlex_back import shlex_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_bundle i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_tok    o_tok,
    output logic    o_run_end
);

    logic [RES_IW-1:0] r_idx;
    logic              take;

    assign o_valid   = !i_empty;
    assign o_tok     = i_head.toks[r_idx];
    assign o_run_end = ({1'b0, r_idx} + 1'b1) == CNT_W'(i_head.count);
    assign take      = o_valid && i_ready;
    // release the bundle once its last word is taken
    assign o_pop     = take && o_run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= o_run_end ? '0 : r_idx + 1'b1;
        end
    end

endmodule

@@ rtl/shell_command_lexer_core.sv @@
// Channel  Dir  tdata           tuser                                     tlast
// s_axis   in   ch[7:0]         has_char                                  line_end
// m_axis   out  tok_char[7:0]   kind[2:0], tok_first, tok_last, empty_tok run_end
//
// One input word is accepted per cycle while the result queue has room.
// Each input word yields zero to three result words; they leave one per cycle
// while the receiver is ready.
// The first result word is offered at the earliest the cycle after its input word.
// The queue holds QUEUE_DEPTH result groups and decouples input from output.
// Reset is synchronous and active low; it clears the lexer state and the queue.
module shell_command_lexer_core import shlex_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // ch
    input  logic       s_axis_tuser,   // has_char
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // tok_char
    output logic [5:0] m_axis_tuser,   // kind[2:0], tok_first, tok_last, empty_tok
    output logic       m_axis_tlast
);

    logic    q_full, q_empty, q_push, q_pop;
    t_bundle q_in, q_head;
    t_tok    out_tok;

    shlex_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_ch       (s_axis_tdata),
        .i_has_char (s_axis_tuser),
        .i_line_end (s_axis_tlast),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_bundle   (q_in)
    );

    shlex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    shlex_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_tok     (out_tok),
        .o_run_end (m_axis_tlast)
    );

    assign m_axis_tdata = out_tok.tok_char;
    assign m_axis_tuser = {out_tok.empty_tok, out_tok.tok_last, out_tok.tok_first,
                           out_tok.kind};

`ifndef NO_ASSERTIONS
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:0] == K_END)) |-> m_axis_tlast)
        else $error("end marker is not the last word of its item");

    a_error_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && (m_axis_tuser[2:0] == K_ERROR))
        |=> (m_axis_tvalid && (m_axis_tuser[2:0] == K_END)))
        else $error("error marker not followed by end marker");

    a_empty_token_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[5])
        |-> (m_axis_tuser[3] && m_axis_tuser[4] && (m_axis_tuser[2:0] == K_WORD)))
        else $error("empty token with wrong flags");
`endif

endmodule

@@ verif/testbench.sv @@
module testbench;
    import shlex_pkg::*;

    localparam int ITEM_GOAL  = 320;
    localparam int CALM_TAIL  = 40;
    localparam int MAX_SHOWN  = 10;
    localparam int LIMIT_TIME = 10_000_000;

    // one result word: tok_char, kind, tok_first, tok_last, empty_tok, run_end
    typedef struct packed {
        logic [7:0] tok_char;
        t_kind      kind;
        logic       tok_first;
        logic       tok_last;
        logic       empty_tok;
        logic       run_end;
    } lex_tok_t;

    typedef struct {
        logic [7:0] ch;
        logic       has_char;
        logic       line_end;
    } lex_in_t;

    // directed row: typed rows carry their results, the rest use the predictor
    typedef struct {
        lex_in_t    item;
        bit         typed;
        int         n_typed;
        lex_tok_t   t0;
        lex_tok_t   t1;
    } lex_row_t;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // ch
    logic       s_axis_tuser  = 1'b0;   // has_char
    logic       s_axis_tlast  = 1'b0;   // line_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // tok_char
    logic [5:0] m_axis_tuser;           // kind[2:0], tok_first, tok_last, empty_tok
    logic       m_axis_tlast;           // run_end

    // lexer state mirror
    t_mode      lx_mode    = M_IDLE;
    logic [7:0] quote_ch   = 8'h00;
    logic       quote_full = 1'b0;
    logic       held_v     = 1'b0;
    logic [7:0] held_ch    = 8'h00;
    t_kind      held_k     = K_WORD;
    logic       held_f     = 1'b0;

    lex_tok_t   step_toks[$];
    lex_tok_t   tokens_due[$];
    lex_row_t   plan[$];
    lex_in_t    line_q[$];

    bit         idle_on    = 1'b1;
    int         mismatches = 0;
    int         items_sent = 0;
    int         stall_left = 0;

    shell_command_lexer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(LIMIT_TIME);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic lex_tok_t tk(logic [7:0] c, t_kind k, logic f, logic l, logic e,
                                    logic r);
        lex_tok_t t;
        t.tok_char  = c;
        t.kind      = k;
        t.tok_first = f;
        t.tok_last  = l;
        t.empty_tok = e;
        t.run_end   = r;
        return t;
    endfunction

    function automatic bit is_gap(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL;
    endfunction

    function automatic bit is_meta(logic [7:0] c);
        return is_gap(c) || c == CH_PIPE || c == CH_AMP || c == CH_SEMI ||
               c == CH_LPAR || c == CH_RPAR || c == CH_LT || c == CH_GT;
    endfunction

    task automatic emit(logic [7:0] c, t_kind k, logic f, logic l, logic e);
        step_toks.push_back(tk(c, k, f, l, e, 1'b0));
    endtask

    task automatic keep(logic [7:0] c, t_kind k, logic f);
        held_v  = 1'b1;
        held_ch = c;
        held_k  = k;
        held_f  = f;
    endtask

    task automatic drop_held();
        held_v  = 1'b0;
        held_ch = 8'h00;
        held_k  = K_WORD;
        held_f  = 1'b0;
    endtask

    // byte that arrives between tokens
    task automatic start_token(logic [7:0] c);
        lx_mode = M_IDLE;
        if (is_gap(c)) begin
        end else if (c == CH_SQUOT || c == CH_DQUOT) begin
            lx_mode    = M_QUOTE;
            quote_ch   = c;
            quote_full = 1'b0;
        end else if (c == CH_PIPE || c == CH_AMP || c == CH_SEMI) begin
            keep(c, K_OP, 1'b1);
            lx_mode = M_OP;
        end else if (c == CH_GT) begin
            keep(c, K_OUT, 1'b1);
            lx_mode = M_OP;
        end else if (c == CH_LT) begin
            emit(c, K_IN, 1'b1, 1'b1, 1'b0);
        end else if (c == CH_LPAR || c == CH_RPAR) begin
            emit(c, K_OP, 1'b1, 1'b1, 1'b0);
        end else begin
            keep(c, K_WORD, 1'b1);
            lx_mode = M_WORD;
        end
    endtask

    task automatic predict_tokens(logic [7:0] c, logic has, logic lend);
        t_kind k;
        logic  f;
        step_toks.delete();
        if (has) begin
            case (lx_mode)
                M_QUOTE: begin
                    if (c == quote_ch) begin
                        if (held_v)
                            emit(held_ch, held_k, held_f, 1'b1, 1'b0);
                        else if (!quote_full)
                            emit(8'h00, K_WORD, 1'b1, 1'b1, 1'b1);
                        drop_held();
                        quote_full = 1'b0;
                        lx_mode    = M_IDLE;
                    end else begin
                        if (held_v)
                            emit(held_ch, held_k, held_f, 1'b0, 1'b0);
                        keep(c, K_WORD, !quote_full);
                        quote_full = 1'b1;
                    end
                end
                M_WORD: begin
                    if (!is_meta(c)) begin
                        f = !held_v;
                        if (held_v)
                            emit(held_ch, held_k, held_f, 1'b0, 1'b0);
                        keep(c, K_WORD, f);
                    end else begin
                        if (held_v)
                            emit(held_ch, held_k, held_f, 1'b1, 1'b0);
                        drop_held();
                        start_token(c);
                    end
                end
                M_OP: begin
                    if (held_v && c == held_ch) begin
                        k = (c == CH_GT) ? K_APPEND : K_OP;
                        emit(held_ch, k, 1'b1, 1'b0, 1'b0);
                        emit(c, k, 1'b0, 1'b1, 1'b0);
                        drop_held();
                        lx_mode = M_IDLE;
                    end else begin
                        if (held_v)
                            emit(held_ch, held_k, 1'b1, 1'b1, 1'b0);
                        drop_held();
                        start_token(c);
                    end
                end
                default: start_token(c);
            endcase
        end
        if (lend) begin
            // an open quote loses its held byte and reports an error
            if (lx_mode == M_QUOTE)
                emit(8'h00, K_ERROR, 1'b1, 1'b1, 1'b0);
            else if (held_v)
                emit(held_ch, held_k, held_f, 1'b1, 1'b0);
            emit(8'h00, K_END, 1'b1, 1'b1, 1'b0);
            lx_mode    = M_IDLE;
            quote_ch   = 8'h00;
            quote_full = 1'b0;
            drop_held();
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size()-1].run_end = 1'b1;
    endtask

    task automatic send_word(lex_in_t it, bit typed, int n_typed, lex_tok_t t0,
                             lex_tok_t t1);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.ch;
        s_axis_tuser  <= it.has_char;
        s_axis_tlast  <= it.line_end;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_tokens(it.ch, it.has_char, it.line_end);
        if (typed) begin
            if (n_typed > 0) tokens_due.push_back(t0);
            if (n_typed > 1) tokens_due.push_back(t1);
        end else begin
            foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
        end
        if (it.has_char || it.line_end)
            items_sent++;
    endtask

    task automatic wait_drained();
        while (tokens_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(logic [7:0] c, logic has, logic lend, bit typed, int n,
                           lex_tok_t t0, lex_tok_t t1);
        lex_row_t r;
        r.item.ch       = c;
        r.item.has_char = has;
        r.item.line_end = lend;
        r.typed         = typed;
        r.n_typed       = n;
        r.t0            = t0;
        r.t1            = t1;
        plan.push_back(r);
    endtask

    task automatic add_byte(logic [7:0] c);
        add_row(c, 1'b1, 1'b0, 1'b0, 0, '0, '0);
    endtask

    task automatic put_in(logic [7:0] c, logic has, logic lend);
        lex_in_t it;
        it.ch       = c;
        it.has_char = has;
        it.line_end = lend;
        line_q.push_back(it);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (is_meta(b) || b == CH_SQUOT || b == CH_DQUOT)
            b = 8'h61 + 8'($urandom_range(0, 25));
        return b;
    endfunction

    function automatic logic [7:0] op_char();
        case ($urandom_range(0, 6))
            0: return CH_PIPE;
            1: return CH_AMP;
            2: return CH_SEMI;
            3: return CH_LPAR;
            4: return CH_RPAR;
            5: return CH_LT;
            default: return CH_GT;
        endcase
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 2))
            0: return CH_SPACE;
            1: return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    // command line with random content
    task automatic build_line();
        logic [7:0] q;
        logic [7:0] c;
        int         n_tok;
        n_tok = $urandom_range(1, 6);
        for (int t = 0; t < n_tok; t++) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    for (int i = $urandom_range(1, 5); i > 0; i--)
                        put_in(word_char(), 1'b1, 1'b0);
                    if ($urandom_range(0, 4) == 0)
                        put_in($urandom_range(0, 1) ? CH_SQUOT : CH_DQUOT, 1'b1, 1'b0);
                end
                2: begin
                    q = $urandom_range(0, 1) ? CH_SQUOT : CH_DQUOT;
                    put_in(q, 1'b1, 1'b0);
                    for (int i = $urandom_range(0, 4); i > 0; i--) begin
                        c = 8'($urandom_range(0, 255));
                        put_in((c == q) ? 8'h2e : c, 1'b1, 1'b0);
                    end
                    put_in(q, 1'b1, 1'b0);
                end
                default: begin
                    c = op_char();
                    put_in(c, 1'b1, 1'b0);
                    if ($urandom_range(0, 1))
                        put_in(c, 1'b1, 1'b0);
                end
            endcase
            for (int i = $urandom_range(0, 2); i > 0; i--)
                put_in(blank_char(), 1'b1, 1'b0);
            if ($urandom_range(0, 7) == 0)
                put_in(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        // leave a quote open now and then
        if ($urandom_range(0, 5) == 0) begin
            put_in($urandom_range(0, 1) ? CH_SQUOT : CH_DQUOT, 1'b1, 1'b0);
            for (int i = $urandom_range(0, 3); i > 0; i--)
                put_in(word_char(), 1'b1, 1'b0);
        end
        if ($urandom_range(0, 1) && line_q[line_q.size()-1].has_char)
            line_q[line_q.size()-1].line_end = 1'b1;
        else
            put_in(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic build_noise();
        for (int i = $urandom_range(1, 8); i > 0; i--)
            put_in(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                   $urandom_range(0, 5) == 0);
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        lex_tok_t got;
        lex_tok_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = tk(m_axis_tdata, t_kind'(m_axis_tuser[2:0]), m_axis_tuser[3],
                     m_axis_tuser[4], m_axis_tuser[5], m_axis_tlast);
            if (tokens_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected word: char %02h kind %0d f%b l%b e%b end%b",
                             got.tok_char, got.kind, got.tok_first, got.tok_last,
                             got.empty_tok, got.run_end);
            end else begin
                want = tokens_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"mismatch: expected char %02h kind %0d f%b l%b e%b end%b,",
                                  " got char %02h kind %0d f%b l%b e%b end%b"},
                                 want.tok_char, want.kind, want.tok_first, want.tok_last,
                                 want.empty_tok, want.run_end,
                                 got.tok_char, got.kind, got.tok_first, got.tok_last,
                                 got.empty_tok, got.run_end);
                end
            end
        end
        if (!idle_on) begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (i_rst_n && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        // after reset
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 1, tk(8'h00, K_END, 1'b1, 1'b1, 1'b0, 1'b1), '0);
        add_row(CH_LT, 1'b1, 1'b0, 1'b1, 1, tk(CH_LT, K_IN, 1'b1, 1'b1, 1'b0, 1'b1), '0);
        add_row(CH_LPAR, 1'b1, 1'b0, 1'b1, 1, tk(CH_LPAR, K_OP, 1'b1, 1'b1, 1'b0, 1'b1),
                '0);
        add_row(CH_RPAR, 1'b1, 1'b0, 1'b1, 1, tk(CH_RPAR, K_OP, 1'b1, 1'b1, 1'b0, 1'b1),
                '0);
        add_row(8'hff, 1'b0, 1'b0, 1'b1, 0, '0, '0);
        // empty quoted pair
        add_row(CH_DQUOT, 1'b1, 1'b0, 1'b1, 0, '0, '0);
        add_row(CH_DQUOT, 1'b1, 1'b0, 1'b1, 1, tk(8'h00, K_WORD, 1'b1, 1'b1, 1'b1, 1'b1),
                '0);
        // quote open at line end
        add_row(CH_SQUOT, 1'b1, 1'b0, 1'b1, 0, '0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 2, tk(8'h00, K_ERROR, 1'b1, 1'b1, 1'b0, 1'b0),
                tk(8'h00, K_END, 1'b1, 1'b1, 1'b0, 1'b1));
        // zero byte and a quote inside a word, then doubled operators
        add_byte(8'hff);
        add_byte(8'h00);
        add_byte(CH_SQUOT);
        add_byte(CH_GT);
        add_byte(CH_GT);
        add_byte(CH_PIPE);
        add_byte(CH_PIPE);
        add_byte(CH_AMP);
        add_byte(CH_AMP);
        add_byte(CH_SEMI);
        add_byte(CH_SEMI);
        // word byte right after a closing quote
        add_byte(CH_SQUOT);
        add_byte("x");
        add_byte(CH_SQUOT);
        add_byte("y");
        add_byte(CH_NL);
        // open quote with content, then a byte together with line end
        add_byte(CH_DQUOT);
        add_byte("a");
        add_byte("b");
        add_row(CH_SPACE, 1'b1, 1'b1, 1'b0, 0, '0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i])
            send_word(plan[i].item, plan[i].typed, plan[i].n_typed, plan[i].t0,
                      plan[i].t1);
        // hold off until the output side has caught up
        s_axis_tvalid <= 1'b0;
        wait_drained();

        while (items_sent < ITEM_GOAL) begin
            if (items_sent >= ITEM_GOAL - CALM_TAIL)
                idle_on = 1'b0;
            else
                idle_on = $urandom_range(0, 3) != 0;
            line_q.delete();
            if ($urandom_range(0, 4) == 0)
                build_noise();
            else
                build_line();
            foreach (line_q[i])
                send_word(line_q[i], 1'b0, 0, '0, '0);
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (16) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0 && tokens_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
